// ===== design/hmbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hmbd_pkg: shared types and constants of the handheld memory bus decoder
// Region codes, I/O slot codes and the decoded item passed front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package hmbd_pkg;

  localparam int RomBankBytes   = 16384;
  localparam int VramBytes      = 8192;
  localparam int WramBytes      = 8192;
  localparam int SpriteRamBytes = 160;
  localparam int HighRamBytes   = 127;

  localparam int VramAw   = $clog2(VramBytes);
  localparam int WramAw   = $clog2(WramBytes);
  localparam int SpriteAw = $clog2(SpriteRamBytes);
  localparam int HighAw   = $clog2(HighRamBytes);
  localparam int RomAw    = 19;

  typedef enum logic [3:0] {
    REG_ROM0, REG_ROMX, REG_VRAM, REG_CRAM, REG_WRAM, REG_SPRITE,
    REG_UNUSED, REG_IO, REG_HRAM, REG_IE
  } region_t;

  // io register slots
  typedef enum logic [4:0] {
    IO_SB, IO_SC, IO_DIV, IO_TIMA, IO_TMA, IO_TAC, IO_IF, IO_LCDC, IO_STAT,
    IO_SCY, IO_SCX, IO_LYC, IO_DMA, IO_BGP, IO_OBP0, IO_OBP1, IO_WY, IO_WX,
    IO_JOYP, IO_LY, IO_BOOT, IO_NONE
  } io_slot_t;

  localparam int IoCount = 18;

  typedef struct packed {
    logic        wr;
    region_t     region;
    io_slot_t    slot;
    logic [12:0] offset;
    logic [13:0] rom_off;
    logic [7:0]  data;
    logic [7:0]  buttons;
    logic [7:0]  line;
  } dec_item_t;

endpackage
`default_nettype wire

// ===== design/handheld_memory_bus_decoder.sv =====
// ----------------------------------------------------------------------------
// handheld_memory_bus_decoder: memory map of a handheld console bus
// Decodes byte accesses into RAMs, I/O registers and banked ROM addresses.
// ----------------------------------------------------------------------------
// Input side is a queue: present an item and raise push; it is taken on a
// clock edge with push high and full low. Result side is a queue too: while
// empty is low the oldest result is on the result ports, and pop on a clock
// edge takes it. Every item gives exactly one result, in order.
// A front stage classifies the address and registers it, a two-entry queue
// decouples it from the back stage, which reads the memory with registered
// data and then holds the result in an output register. With pop held high
// one item per cycle is sustained, limited by the single port of each RAM.
// Reset (rst, synchronous) empties all stages, sets the ROM bank to 1, the
// joypad select to 0xCF and clears the I/O registers and interrupt enable.
// RAM contents are not cleared and must be written before being read.
// When pop stays low, results back up through the stages and full rises.
// ----------------------------------------------------------------------------
`default_nettype none
module handheld_memory_bus_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        req_type,
  input  wire logic [15:0] bus_addr,
  input  wire logic [7:0]  write_data,
  input  wire logic [7:0]  button_state,
  input  wire logic [7:0]  current_line,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       read_data,
  output logic             rom_fetch,
  output logic [18:0]      rom_address,
  output logic             lcd_turned_on,
  output logic             lcd_turned_off,
  output logic             dma_request,
  output logic [7:0]       dma_source_page
);

  logic in_ready;
  logic f_valid;
  logic f_ready;
  logic q_valid;
  logic q_ready;
  hmbd_pkg::dec_item_t f_item;
  hmbd_pkg::dec_item_t q_item;

  assign full = !in_ready;

  hmbd_front u_front (
    .clk, .rst,
    .in_valid(push), .in_ready,
    .req_type, .bus_addr, .write_data, .button_state, .current_line,
    .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
  );

  hmbd_queue u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  hmbd_back u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .empty, .pop,
    .read_data, .rom_fetch, .rom_address, .lcd_turned_on, .lcd_turned_off,
    .dma_request, .dma_source_page
  );

endmodule
`default_nettype wire

// ===== design/hmbd_front.sv =====
// ----------------------------------------------------------------------------
// hmbd_front: address classification
// Registers each accepted item with its region, io slot and local offset.
// ----------------------------------------------------------------------------
`default_nettype none
module hmbd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               req_type,
  input  wire logic [15:0]        bus_addr,
  input  wire logic [7:0]         write_data,
  input  wire logic [7:0]         button_state,
  input  wire logic [7:0]         current_line,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hmbd_pkg::dec_item_t     out_item
);

  hmbd_pkg::dec_item_t item_next;
  logic [15:0] off16;
  logic [7:0]  sprite_off;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    item_next = '0;
    item_next.wr = req_type;
    item_next.data = write_data;
    item_next.buttons = button_state;
    item_next.line = current_line;
    item_next.rom_off = bus_addr[13:0];
    item_next.slot = hmbd_pkg::IO_NONE;
    off16 = 16'(bus_addr - 16'hE000);
    sprite_off = 8'(bus_addr - 16'hFE00);
    if (bus_addr < 16'h4000) item_next.region = hmbd_pkg::REG_ROM0;
    else if (bus_addr < 16'h8000) item_next.region = hmbd_pkg::REG_ROMX;
    else if (bus_addr < 16'hA000) item_next.region = hmbd_pkg::REG_VRAM;
    else if (bus_addr < 16'hC000) item_next.region = hmbd_pkg::REG_CRAM;
    else if (bus_addr < 16'hFE00) item_next.region = hmbd_pkg::REG_WRAM;
    else if (bus_addr < 16'hFEA0) item_next.region = hmbd_pkg::REG_SPRITE;
    else if (bus_addr < 16'hFF00) item_next.region = hmbd_pkg::REG_UNUSED;
    else if (bus_addr < 16'hFF80) item_next.region = hmbd_pkg::REG_IO;
    else if (bus_addr < 16'hFFFF) item_next.region = hmbd_pkg::REG_HRAM;
    else item_next.region = hmbd_pkg::REG_IE;
    unique case (item_next.region)
      hmbd_pkg::REG_VRAM:   item_next.offset = bus_addr[12:0];
      hmbd_pkg::REG_WRAM:   item_next.offset = (bus_addr < 16'hE000) ?
                              bus_addr[12:0] : off16[12:0];
      hmbd_pkg::REG_SPRITE: item_next.offset = {5'd0, sprite_off};
      hmbd_pkg::REG_HRAM:   item_next.offset = {6'd0, bus_addr[6:0]};
      default:              item_next.offset = '0;
    endcase
    unique case (bus_addr[7:0])
      8'h00: item_next.slot = hmbd_pkg::IO_JOYP;
      8'h01: item_next.slot = hmbd_pkg::IO_SB;
      8'h02: item_next.slot = hmbd_pkg::IO_SC;
      8'h04: item_next.slot = hmbd_pkg::IO_DIV;
      8'h05: item_next.slot = hmbd_pkg::IO_TIMA;
      8'h06: item_next.slot = hmbd_pkg::IO_TMA;
      8'h07: item_next.slot = hmbd_pkg::IO_TAC;
      8'h0F: item_next.slot = hmbd_pkg::IO_IF;
      8'h40: item_next.slot = hmbd_pkg::IO_LCDC;
      8'h41: item_next.slot = hmbd_pkg::IO_STAT;
      8'h42: item_next.slot = hmbd_pkg::IO_SCY;
      8'h43: item_next.slot = hmbd_pkg::IO_SCX;
      8'h44: item_next.slot = hmbd_pkg::IO_LY;
      8'h45: item_next.slot = hmbd_pkg::IO_LYC;
      8'h46: item_next.slot = hmbd_pkg::IO_DMA;
      8'h47: item_next.slot = hmbd_pkg::IO_BGP;
      8'h48: item_next.slot = hmbd_pkg::IO_OBP0;
      8'h49: item_next.slot = hmbd_pkg::IO_OBP1;
      8'h4A: item_next.slot = hmbd_pkg::IO_WY;
      8'h4B: item_next.slot = hmbd_pkg::IO_WX;
      8'h50: item_next.slot = hmbd_pkg::IO_BOOT;
      default: item_next.slot = hmbd_pkg::IO_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/hmbd_queue.sv =====
// ----------------------------------------------------------------------------
// hmbd_queue: two-entry queue of decoded items between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module hmbd_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  hmbd_pkg::dec_item_t      in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hmbd_pkg::dec_item_t      out_item
);

  hmbd_pkg::dec_item_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_item  = slots[rptr];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= !wptr;
      if (do_pop) rptr <= !rptr;
      count <= 2'(count + {1'b0, do_push} - {1'b0, do_pop});
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= in_item;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !do_pop) |=> count == 2'd2)
    else $error("queue lost an item");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 && !do_push) |=> count == 2'd0)
    else $error("queue invented an item");

endmodule
`default_nettype wire

// ===== design/hmbd_back.sv =====
// ----------------------------------------------------------------------------
// hmbd_back: access execution
// Owns the RAMs and registers; a two-stage pipe reads memories with
// registered data and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module hmbd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  hmbd_pkg::dec_item_t     in_item,
  output logic                    empty,
  input  wire logic               pop,
  output logic [7:0]              read_data,
  output logic                    rom_fetch,
  output logic [18:0]             rom_address,
  output logic                    lcd_turned_on,
  output logic                    lcd_turned_off,
  output logic                    dma_request,
  output logic [7:0]              dma_source_page
);

  logic [7:0] vram   [hmbd_pkg::VramBytes];
  logic [7:0] wram   [hmbd_pkg::WramBytes];
  logic [7:0] sprite [hmbd_pkg::SpriteRamBytes];
  logic [7:0] hram   [hmbd_pkg::HighRamBytes];

  logic [4:0] rom_bank;
  logic [7:0] joypad_select;
  logic [7:0] io_regs [hmbd_pkg::IoCount];
  logic [4:0] interrupt_enable;

  // stage 2: registered memory/register read
  logic                 s2_valid;
  hmbd_pkg::region_t    s2_region;
  logic                 s2_wr;
  logic [7:0]           s2_mem;
  logic [7:0]           s2_reg;
  logic                 s2_rom;
  logic [18:0]          s2_rom_addr;
  logic                 s2_on;
  logic                 s2_off;
  logic                 s2_dma;
  logic [7:0]           s2_dma_page;

  logic out_valid;
  logic s2_adv;
  logic take;
  logic [7:0] reg_rd;
  logic [3:0] nib;
  logic [4:0] bank_w;
  logic [4:0] slot_idx;

  assign empty    = !out_valid;
  assign s2_adv   = !out_valid || pop;
  assign in_ready = !s2_valid || s2_adv;
  assign take     = in_valid && in_ready;
  assign slot_idx = in_item.slot;
  assign bank_w   = (in_item.data[4:0] == 5'd0) ? 5'd1 : in_item.data[4:0];

  always_comb begin
    nib = 4'hF;
    if (!joypad_select[4]) nib = nib & ~in_item.buttons[3:0];
    if (!joypad_select[5]) nib = nib & ~in_item.buttons[7:4];
    unique case (in_item.slot)
      hmbd_pkg::IO_JOYP: reg_rd = {joypad_select[7:4], nib};
      hmbd_pkg::IO_SC:   reg_rd = io_regs[hmbd_pkg::IO_SC] | 8'h7E;
      hmbd_pkg::IO_TAC:  reg_rd = io_regs[hmbd_pkg::IO_TAC] | 8'hF8;
      hmbd_pkg::IO_IF:   reg_rd = io_regs[hmbd_pkg::IO_IF] | 8'hE0;
      hmbd_pkg::IO_STAT: reg_rd = io_regs[hmbd_pkg::IO_STAT] | 8'h80;
      hmbd_pkg::IO_LY:   reg_rd = in_item.line;
      hmbd_pkg::IO_BOOT: reg_rd = 8'h01;
      hmbd_pkg::IO_DMA, hmbd_pkg::IO_NONE: reg_rd = 8'hFF;
      default:           reg_rd = io_regs[slot_idx];
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (take) begin
      if (in_item.wr) begin
        unique case (in_item.region)
          hmbd_pkg::REG_VRAM:   vram[in_item.offset] <= in_item.data;
          hmbd_pkg::REG_WRAM:   wram[in_item.offset] <= in_item.data;
          hmbd_pkg::REG_SPRITE:
            sprite[in_item.offset[hmbd_pkg::SpriteAw-1:0]] <= in_item.data;
          hmbd_pkg::REG_HRAM:
            hram[in_item.offset[hmbd_pkg::HighAw-1:0]] <= in_item.data;
          default: ;
        endcase
      end else begin
        unique case (in_item.region)
          hmbd_pkg::REG_VRAM:   s2_mem <= vram[in_item.offset];
          hmbd_pkg::REG_WRAM:   s2_mem <= wram[in_item.offset];
          hmbd_pkg::REG_SPRITE:
            s2_mem <= sprite[in_item.offset[hmbd_pkg::SpriteAw-1:0]];
          hmbd_pkg::REG_HRAM:
            s2_mem <= hram[in_item.offset[hmbd_pkg::HighAw-1:0]];
          default: s2_mem <= 8'h00;
        endcase
      end
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank         <= 5'd1;
      joypad_select    <= 8'hCF;
      interrupt_enable <= 5'd0;
      for (int i = 0; i < hmbd_pkg::IoCount; i++) io_regs[i] <= 8'h00;
    end else if (take && in_item.wr) begin
      unique case (in_item.region)
        hmbd_pkg::REG_ROM0: rom_bank <= bank_w;
        hmbd_pkg::REG_IE:   interrupt_enable <= in_item.data[4:0];
        hmbd_pkg::REG_IO: begin
          unique case (in_item.slot)
            hmbd_pkg::IO_JOYP:
              joypad_select <= (joypad_select & 8'hCF) | (in_item.data & 8'h30);
            hmbd_pkg::IO_SC:  io_regs[hmbd_pkg::IO_SC] <= in_item.data & 8'h83;
            hmbd_pkg::IO_DIV: io_regs[hmbd_pkg::IO_DIV] <= 8'h00;
            hmbd_pkg::IO_TAC: io_regs[hmbd_pkg::IO_TAC] <= in_item.data & 8'h07;
            hmbd_pkg::IO_IF:  io_regs[hmbd_pkg::IO_IF] <= in_item.data & 8'h1F;
            hmbd_pkg::IO_STAT:
              io_regs[hmbd_pkg::IO_STAT] <= (io_regs[hmbd_pkg::IO_STAT] & 8'h03)
                                            | (in_item.data & 8'hFC);
            hmbd_pkg::IO_LY, hmbd_pkg::IO_BOOT, hmbd_pkg::IO_NONE: ;
            default: io_regs[slot_idx] <= in_item.data;
          endcase
        end
        default: ;
      endcase
    end
  end

  // stage 2 control and side results
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_ready) begin
      s2_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s2_region   <= in_item.region;
      s2_wr       <= in_item.wr;
      s2_reg      <= (in_item.region == hmbd_pkg::REG_IO) ? reg_rd :
                     (in_item.region == hmbd_pkg::REG_IE) ?
                     {3'd0, interrupt_enable} : 8'hFF;
      s2_rom      <= !in_item.wr && (in_item.region == hmbd_pkg::REG_ROM0 ||
                                     in_item.region == hmbd_pkg::REG_ROMX);
      s2_rom_addr <= (in_item.region == hmbd_pkg::REG_ROMX) ?
                     {rom_bank, in_item.rom_off} : {5'd0, in_item.rom_off};
      s2_on  <= in_item.wr && in_item.region == hmbd_pkg::REG_IO &&
                in_item.slot == hmbd_pkg::IO_LCDC &&
                !io_regs[hmbd_pkg::IO_LCDC][7] && in_item.data[7];
      s2_off <= in_item.wr && in_item.region == hmbd_pkg::REG_IO &&
                in_item.slot == hmbd_pkg::IO_LCDC &&
                io_regs[hmbd_pkg::IO_LCDC][7] && !in_item.data[7];
      s2_dma <= in_item.wr && in_item.region == hmbd_pkg::REG_IO &&
                in_item.slot == hmbd_pkg::IO_DMA;
      s2_dma_page <= in_item.data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_valid) begin
      rom_fetch       <= s2_rom;
      rom_address     <= s2_rom ? s2_rom_addr : 19'd0;
      lcd_turned_on   <= s2_on;
      lcd_turned_off  <= s2_off;
      dma_request     <= s2_dma;
      dma_source_page <= s2_dma ? s2_dma_page : 8'd0;
      if (s2_wr) begin
        read_data <= 8'h00;
      end else begin
        unique case (s2_region)
          hmbd_pkg::REG_ROM0, hmbd_pkg::REG_ROMX, hmbd_pkg::REG_CRAM:
            read_data <= 8'h00;
          hmbd_pkg::REG_VRAM, hmbd_pkg::REG_WRAM, hmbd_pkg::REG_SPRITE,
          hmbd_pkg::REG_HRAM:
            read_data <= s2_mem;
          default: read_data <= s2_reg;
        endcase
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(lcd_turned_on && lcd_turned_off))
    else $error("lcd on and off together");
  assert property (@(posedge clk) disable iff (rst)
    (!empty && rom_fetch) |-> (read_data == 8'h00 && !dma_request))
    else $error("rom fetch with data");
  assert property (@(posedge clk) disable iff (rst)
    rom_bank != 5'd0)
    else $error("rom bank zero");

endmodule
`default_nettype wire
